// File: hdl/stt_pkg.sv
// Shared types and constants for the software timer table.
package stt_pkg;

    localparam int TIMER_INDEX_W = 4;

    localparam logic [2:0] KIND_ALLOC = 3'd0;
    localparam logic [2:0] KIND_FREE  = 3'd1;
    localparam logic [2:0] KIND_BIND  = 3'd2;
    localparam logic [2:0] KIND_ARM   = 3'd3;
    localparam logic [2:0] KIND_TICK  = 3'd4;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_ARMED = 2'd2;

    localparam logic       RK_ALLOC  = 1'b0;
    localparam logic       RK_EXPIRY = 1'b1;

    localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;
    localparam logic [4:0]  MAX_EXPIRY  = 5'd16;

    // Broadcast to every cell in the beat an item is accepted.
    typedef struct packed {
        logic                     we;
        logic [2:0]               kind;
        logic [TIMER_INDEX_W-1:0] index;
        logic [3:0]               fifo_id;
        logic [7:0]               event_data;
        logic [31:0]              deadline;
    } stt_cmd_t;

    // Scan token walking down the cell chain.
    typedef struct packed {
        logic        op_tick;
        logic        found;
        logic [3:0]  slot;
        logic [31:0] count;
        logic [31:0] min_dl;
        logic [4:0]  n_exp;
    } stt_token_t;

    // Expiry record raised by the cell that holds the token.
    typedef struct packed {
        logic       hit;
        logic [3:0] slot;
        logic [3:0] dest_fifo;
        logic [7:0] event_byte;
    } stt_expiry_t;

endpackage

// File: hdl/stt_cell.sv
// One timer slot: status, deadline, queue id and event byte, with its stage of the scan token.
module stt_cell #(
    parameter int INDEX         = 0,
    parameter int QUEUE_ID_BITS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  stt_pkg::stt_cmd_t   cmd,
    input  logic                tok_in_valid,
    input  stt_pkg::stt_token_t tok_in,
    output logic                tok_out_valid,
    output stt_pkg::stt_token_t tok_out,
    output stt_pkg::stt_expiry_t expiry
);
    import stt_pkg::*;

    localparam bit         ADDRESSABLE = (INDEX < (1 << TIMER_INDEX_W));
    localparam logic [3:0] MY_SLOT     = 4'(INDEX);
    localparam logic [TIMER_INDEX_W-1:0] MY_ADDR = TIMER_INDEX_W'(INDEX);

    logic [1:0]               status_reg, status_next;
    logic [31:0]              deadline_reg;
    logic [QUEUE_ID_BITS-1:0] queue_reg;
    logic [7:0]               event_reg;
    logic                     tok_valid_reg;
    stt_token_t               tok_reg, tok_next;
    logic                     addressed;
    logic                     take;
    logic [QUEUE_ID_BITS+3:0] queue_wide_in;
    logic [QUEUE_ID_BITS+3:0] queue_wide_out;

    assign addressed      = ADDRESSABLE && cmd.we && (cmd.index == MY_ADDR);
    assign take           = tok_in_valid && advance;
    assign queue_wide_in  = {{QUEUE_ID_BITS{1'b0}}, cmd.fifo_id};
    assign queue_wide_out = {4'b0000, queue_reg};

    always_comb begin
        status_next = status_reg;
        tok_next    = tok_in;
        expiry      = '0;
        if (take) begin
            if (tok_in.op_tick) begin
                if (status_reg == ST_ARMED) begin
                    if ((deadline_reg <= tok_in.count) && (tok_in.n_exp < MAX_EXPIRY)) begin
                        status_next       = ST_ALLOC;
                        tok_next.n_exp    = tok_in.n_exp + 5'd1;
                        expiry.hit        = 1'b1;
                        expiry.slot       = MY_SLOT;
                        expiry.dest_fifo  = queue_wide_out[3:0];
                        expiry.event_byte = event_reg;
                    end else if (deadline_reg < tok_in.min_dl) begin
                        tok_next.min_dl = deadline_reg;
                    end
                end
            end else if (!tok_in.found && (status_reg == ST_FREE)) begin
                status_next    = ST_ALLOC;
                tok_next.found = 1'b1;
                tok_next.slot  = MY_SLOT;
            end
        end else if (addressed) begin
            case (cmd.kind)
                KIND_FREE: status_next = ST_FREE;
                KIND_ARM:  status_next = ST_ARMED;
                default:   status_next = status_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg    <= ST_FREE;
            tok_valid_reg <= 1'b0;
        end else begin
            status_reg <= status_next;
            if (advance) begin
                tok_valid_reg <= tok_in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tok_reg <= tok_next;
        end
        if (addressed && (cmd.kind == KIND_BIND)) begin
            queue_reg <= queue_wide_in[QUEUE_ID_BITS-1:0];
            event_reg <= cmd.event_data;
        end
        if (addressed && (cmd.kind == KIND_ARM)) begin
            deadline_reg <= cmd.deadline;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// File: hdl/software_timer_table_top.sv
// Top level of the software timer table: command decode, cell chain, result staging.
//
//  channel | dir | tdata                                  | tuser          | tlast
//  s_      | in  | timer_index, fifo_id, event_data, timeout | kind         | -
//  m_      | out | alloc_ok, slot_index, dest_fifo, event_byte | result_kind | last
//
// Free, bind, arm and a tick with nothing due leave s_tready high for the next beat.
// Allocate and a due tick send a token down the row of NUM_TIMERS cells, one cell a
// cycle while m_ does not stall; s_tready drops after the accept and returns only
// after the end of the scan.
// While the token is held by a stalled result register the whole row holds.
// Synchronous active-low reset frees every slot; deadlines, queues and events keep
// no reset value.
module software_timer_table_top #(
    parameter int NUM_TIMERS    = 16,
    parameter int QUEUE_ID_BITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // timer_index[3:0], fifo_id[7:4], event_data[15:8], timeout[47:16]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // alloc_ok[0], slot_index[4:1], dest_fifo[8:5], event_byte[16:9]
    output logic [0:0]  m_tuser,   // result_kind[0]
    output logic        m_tlast
);
    import stt_pkg::*;

    logic [2:0]  in_kind;
    logic [3:0]  in_index;
    logic [3:0]  in_fifo;
    logic [7:0]  in_event;
    logic [31:0] in_timeout;

    logic        accept;
    logic        out_free;
    logic        advance;
    logic        idx_in_range;
    logic [31:0] tick_inc;
    logic [31:0] arm_dl;
    logic        due;
    logic        launch;
    logic        scan_end;

    logic [31:0] tick_count_reg, tick_count_next;
    logic [31:0] next_deadline_reg, next_deadline_next;
    logic        busy_reg, busy_next;
    logic        launch_valid_reg, launch_valid_next;
    stt_token_t  launch_tok_reg;

    logic        pend_valid_reg, pend_valid_next;
    stt_expiry_t pend_reg, pend_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic        out_ok_reg, out_ok_next;
    logic [3:0]  out_slot_reg, out_slot_next;
    logic [3:0]  out_dest_reg, out_dest_next;
    logic [7:0]  out_event_reg, out_event_next;
    logic        out_last_reg, out_last_next;

    stt_cmd_t    cmd;
    logic        tok_valid [0:NUM_TIMERS];
    stt_token_t  tok       [0:NUM_TIMERS];
    stt_expiry_t cell_exp  [NUM_TIMERS];
    stt_expiry_t hit;

    assign in_index   = s_tdata[3:0];
    assign in_fifo    = s_tdata[7:4];
    assign in_event   = s_tdata[15:8];
    assign in_timeout = s_tdata[47:16];
    assign in_kind    = s_tuser;

    assign s_tready     = !busy_reg;
    assign accept       = s_tvalid && s_tready;
    assign out_free     = !out_valid_reg || m_tready;
    assign advance      = out_free;
    assign idx_in_range = (32'(in_index) < 32'(NUM_TIMERS));
    assign tick_inc     = tick_count_reg + 32'd1;
    assign arm_dl       = in_timeout + tick_count_reg;
    assign due          = (next_deadline_reg <= tick_inc);
    assign launch       = accept && ((in_kind == KIND_ALLOC) || ((in_kind == KIND_TICK) && due));
    assign scan_end     = tok_valid[NUM_TIMERS] && advance;

    assign cmd.we         = accept;
    assign cmd.kind       = in_kind;
    assign cmd.index      = in_index;
    assign cmd.fifo_id    = in_fifo;
    assign cmd.event_data = in_event;
    assign cmd.deadline   = arm_dl;

    assign tok_valid[0] = launch_valid_reg;
    assign tok[0]       = launch_tok_reg;

    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
        stt_cell #(
            .INDEX         (k),
            .QUEUE_ID_BITS (QUEUE_ID_BITS)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .advance       (advance),
            .cmd           (cmd),
            .tok_in_valid  (tok_valid[k]),
            .tok_in        (tok[k]),
            .tok_out_valid (tok_valid[k+1]),
            .tok_out       (tok[k+1]),
            .expiry        (cell_exp[k])
        );
    end

    // Only the cell holding the token can raise a hit, so an OR collects it.
    always_comb begin
        hit = '0;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            hit = hit | cell_exp[k];
        end
    end

    always_comb begin
        tick_count_next    = tick_count_reg;
        next_deadline_next = next_deadline_reg;
        busy_next          = busy_reg;
        launch_valid_next  = launch_valid_reg;

        if (accept && (in_kind == KIND_TICK)) begin
            tick_count_next = tick_inc;
        end
        if (accept && (in_kind == KIND_ARM) && idx_in_range && (arm_dl < next_deadline_reg)) begin
            next_deadline_next = arm_dl;
        end
        if (scan_end && tok[NUM_TIMERS].op_tick) begin
            next_deadline_next = tok[NUM_TIMERS].min_dl;
        end

        if (launch) begin
            busy_next = 1'b1;
        end else if (scan_end) begin
            busy_next = 1'b0;
        end

        if (launch) begin
            launch_valid_next = 1'b1;
        end else if (advance) begin
            launch_valid_next = 1'b0;
        end
    end

    // Hold each expiry one step in pend so the final one can carry last.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_ok_next     = out_ok_reg;
        out_slot_next   = out_slot_reg;
        out_dest_next   = out_dest_reg;
        out_event_next  = out_event_reg;
        out_last_next   = out_last_reg;

        if (hit.hit) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_kind_next  = RK_EXPIRY;
                out_ok_next    = 1'b0;
                out_slot_next  = pend_reg.slot;
                out_dest_next  = pend_reg.dest_fifo;
                out_event_next = pend_reg.event_byte;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = hit;
        end else if (scan_end) begin
            if (tok[NUM_TIMERS].op_tick) begin
                if (pend_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RK_EXPIRY;
                    out_ok_next    = 1'b0;
                    out_slot_next  = pend_reg.slot;
                    out_dest_next  = pend_reg.dest_fifo;
                    out_event_next = pend_reg.event_byte;
                    out_last_next  = 1'b1;
                end
                pend_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b1;
                out_kind_next  = RK_ALLOC;
                out_ok_next    = tok[NUM_TIMERS].found;
                out_slot_next  = tok[NUM_TIMERS].found ? tok[NUM_TIMERS].slot : 4'd0;
                out_dest_next  = 4'd0;
                out_event_next = 8'd0;
                out_last_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg    <= 32'd0;
            next_deadline_reg <= NO_DEADLINE;
            busy_reg          <= 1'b0;
            launch_valid_reg  <= 1'b0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            tick_count_reg    <= tick_count_next;
            next_deadline_reg <= next_deadline_next;
            busy_reg          <= busy_next;
            launch_valid_reg  <= launch_valid_next;
            pend_valid_reg    <= pend_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (launch) begin
            launch_tok_reg.op_tick <= (in_kind == KIND_TICK);
            launch_tok_reg.found   <= 1'b0;
            launch_tok_reg.slot    <= 4'd0;
            launch_tok_reg.count   <= tick_inc;
            launch_tok_reg.min_dl  <= NO_DEADLINE;
            launch_tok_reg.n_exp   <= 5'd0;
        end
        pend_reg      <= pend_next;
        out_kind_reg  <= out_kind_next;
        out_ok_reg    <= out_ok_next;
        out_slot_reg  <= out_slot_next;
        out_dest_reg  <= out_dest_next;
        out_event_reg <= out_event_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_event_reg, out_dest_reg, out_slot_reg, out_ok_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hdl/stt_checker.sv
// Port-level checks on the software timer table, bound to its top level.
module stt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);
    import stt_pkg::*;

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // An allocate starts a scan, so no item is taken right after it.
    a_alloc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_ALLOC) |=> !s_tready)
        else $error("input accepted during allocation scan");

    a_alloc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == RK_ALLOC) |->
        m_tlast && (m_tdata[8:5] == 4'd0) && (m_tdata[16:9] == 8'd0))
        else $error("allocation answer malformed");

    a_alloc_fail_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == RK_ALLOC) && !m_tdata[0] |-> (m_tdata[4:1] == 4'd0))
        else $error("failed allocation reports a slot");

    a_expiry_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == RK_EXPIRY) |-> !m_tdata[0] && (m_tdata[23:17] == 7'd0))
        else $error("expiry beat malformed");

endmodule

bind software_timer_table_top stt_checker u_stt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: tb/testbench.sv
// Self-checking testbench for the software timer table: random commands against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int NUM_SLOTS     = 16;
    localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 8;

    // Kinds the block must ignore
    localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
    localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  index;
        logic [3:0]  fifo_id;
        logic [7:0]  event_data;
        logic [31:0] timeout;
    } timer_cmd_t;

    typedef struct packed {
        logic       result_kind;
        logic       alloc_ok;
        logic [3:0] slot_index;
        logic [3:0] dest_fifo;
        logic [7:0] event_byte;
        logic       last;
    } timer_reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    software_timer_table_top #(
        .NUM_TIMERS   (NUM_SLOTS),
        .QUEUE_ID_BITS(4)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Predicted timer table
    logic [31:0] tick_count;
    logic [31:0] next_deadline;
    logic [1:0]  slot_state    [NUM_SLOTS];
    logic [31:0] slot_deadline [NUM_SLOTS];
    logic [3:0]  slot_queue    [NUM_SLOTS];
    logic [7:0]  slot_event    [NUM_SLOTS];

    timer_reply_t due_replies[$];
    timer_cmd_t   pending_cmds[$];
    bit           slot_bound[NUM_SLOTS];
    int           cmds_queued;
    int           mismatches;
    int           send_idle_pct;
    int           recv_idle_pct;

    function automatic void reset_timer_table();
        tick_count    = '0;
        next_deadline = NO_DEADLINE;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_state[i]    = ST_FREE;
            slot_deadline[i] = '0;
            slot_queue[i]    = '0;
            slot_event[i]    = '0;
        end
    endfunction

    function automatic void apply_timer_command(timer_cmd_t c);
        timer_reply_t r;
        timer_reply_t hits[$];
        logic [31:0]  dl;
        r = '0;
        case (c.kind)
            KIND_ALLOC: begin
                r.result_kind = RK_ALLOC;
                r.last        = 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_state[i] == ST_FREE) begin
                        slot_state[i] = ST_ALLOC;
                        r.alloc_ok    = 1'b1;
                        r.slot_index  = i[3:0];
                        break;
                    end
                end
                due_replies.push_back(r);
            end
            KIND_FREE: slot_state[c.index] = ST_FREE;
            KIND_BIND: begin
                slot_queue[c.index] = c.fifo_id;
                slot_event[c.index] = c.event_data;
            end
            KIND_ARM: begin
                dl = c.timeout + tick_count;
                slot_deadline[c.index] = dl;
                slot_state[c.index]    = ST_ARMED;
                if (next_deadline > dl)
                    next_deadline = dl;
            end
            KIND_TICK: begin
                tick_count = tick_count + 1;
                if (next_deadline <= tick_count) begin
                    next_deadline = NO_DEADLINE;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_state[i] == ST_ARMED) begin
                            if (slot_deadline[i] <= tick_count && hits.size() < MAX_EXPIRY) begin
                                slot_state[i] = ST_ALLOC;
                                r             = '0;
                                r.result_kind = RK_EXPIRY;
                                r.slot_index  = i[3:0];
                                r.dest_fifo   = slot_queue[i];
                                r.event_byte  = slot_event[i];
                                hits.push_back(r);
                            end else if (next_deadline > slot_deadline[i]) begin
                                next_deadline = slot_deadline[i];
                            end
                        end
                    end
                    foreach (hits[j]) begin
                        r      = hits[j];
                        r.last = (j == hits.size() - 1);
                        due_replies.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Driver: hold the beat until accepted, then maybe idle
    always @(posedge aclk) begin
        timer_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                c = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {c.timeout, c.event_data, c.fifo_id, c.index};
                s_tuser  <= c.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on each accepted command, check each result beat
    always @(posedge aclk) begin
        timer_cmd_t   c;
        timer_reply_t got;
        timer_reply_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                c.kind       = s_tuser;
                c.index      = s_tdata[3:0];
                c.fifo_id    = s_tdata[7:4];
                c.event_data = s_tdata[15:8];
                c.timeout    = s_tdata[47:16];
                apply_timer_command(c);
            end
            if (m_tvalid && m_tready) begin
                got.result_kind = m_tuser[0];
                got.alloc_ok    = m_tdata[0];
                got.slot_index  = m_tdata[4:1];
                got.dest_fifo   = m_tdata[8:5];
                got.event_byte  = m_tdata[16:9];
                got.last        = m_tlast;
                if (due_replies.size() == 0) begin
                    $error("unexpected result beat: kind %0d slot %0d",
                           got.result_kind, got.slot_index);
                    mismatches++;
                end else begin
                    want = due_replies.pop_front();
                    check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
                    check_field("alloc_ok", 32'(want.alloc_ok), 32'(got.alloc_ok));
                    check_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
                    check_field("dest_fifo", 32'(want.dest_fifo), 32'(got.dest_fifo));
                    check_field("event_byte", 32'(want.event_byte), 32'(got.event_byte));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
            end
        end
    end

    function automatic timer_cmd_t make_cmd(logic [2:0] kind, logic [3:0] index,
                                            logic [3:0] fifo_id, logic [7:0] event_data,
                                            logic [31:0] timeout);
        timer_cmd_t c;
        c.kind       = kind;
        c.index      = index;
        c.fifo_id    = fifo_id;
        c.event_data = event_data;
        c.timeout    = timeout;
        return c;
    endfunction

    // Random content in every field; the kind decides which ones matter
    function automatic timer_cmd_t random_cmd(logic [2:0] kind);
        return make_cmd(kind, 4'($urandom), 4'($urandom), 8'($urandom), $urandom);
    endfunction

    function automatic logic [31:0] pick_timeout();
        int p;
        p = $urandom_range(99);
        if (p < 60)
            return 32'($urandom_range(12));
        else if (p < 80)
            return $urandom;
        // wraps to a deadline just below the current count
        return NO_DEADLINE - 32'($urandom_range(40));
    endfunction

    task automatic push_cmd(timer_cmd_t c);
        if (c.kind == KIND_BIND)
            slot_bound[c.index] = 1'b1;
        // never let an unbound slot expire
        if (c.kind == KIND_ARM && !slot_bound[c.index])
            push_cmd(make_cmd(KIND_BIND, c.index, 4'($urandom), 8'($urandom), $urandom));
        if (c.kind <= KIND_TICK)
            cmds_queued++;
        pending_cmds.push_back(c);
    endtask

    task automatic random_step();
        timer_cmd_t c;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 14) begin
            // bind, arm and run the clock toward the deadline
            c = random_cmd(KIND_BIND);
            push_cmd(c);
            c.kind    = KIND_ARM;
            c.timeout = 32'($urandom_range(6));
            push_cmd(c);
            repeat ($urandom_range(1, 5)) push_cmd(random_cmd(KIND_TICK));
        end else if (pick < 28) begin
            push_cmd(random_cmd(KIND_ALLOC));
        end else if (pick < 38) begin
            push_cmd(random_cmd(KIND_FREE));
        end else if (pick < 48) begin
            push_cmd(random_cmd(KIND_BIND));
        end else if (pick < 64) begin
            c = random_cmd(KIND_ARM);
            c.timeout = pick_timeout();
            push_cmd(c);
        end else if (pick < 95) begin
            push_cmd(random_cmd(KIND_TICK));
        end else begin
            push_cmd(random_cmd(3'($urandom_range(KIND_RSVD_LAST, KIND_RSVD_FIRST))));
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || due_replies.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        reset_timer_table();
        mismatches    = 0;
        cmds_queued   = 0;
        send_idle_pct = 6;
        recv_idle_pct = 76;
        foreach (slot_bound[i]) slot_bound[i] = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // fill the table, then one allocation too many
        for (int i = 0; i <= NUM_SLOTS; i++)
            push_cmd(make_cmd(KIND_ALLOC, i[0] ? '1 : '0, i[0] ? '1 : '0,
                              i[0] ? '1 : '0, i[0] ? '1 : '0));
        push_cmd(make_cmd(KIND_BIND, 4'd0, 4'hf, 8'hff, '0));
        push_cmd(make_cmd(KIND_BIND, 4'd15, 4'h0, 8'h00, '1));
        push_cmd(make_cmd(KIND_ARM, 4'd15, '0, '0, 32'd0));
        push_cmd(make_cmd(KIND_ARM, 4'd0, '0, '0, 32'hffff_ffff));
        push_cmd(make_cmd(KIND_TICK, '1, '1, '1, '1));
        push_cmd(make_cmd(KIND_TICK, '0, '0, '0, '0));
        // deadline wraps past the count
        push_cmd(make_cmd(KIND_ARM, 4'd15, '0, '0, 32'hffff_ffff));
        // cancel an armed slot; the earliest deadline stays put
        push_cmd(make_cmd(KIND_FREE, 4'd0, '1, '1, '1));
        push_cmd(make_cmd(KIND_TICK, '0, '0, '0, '0));
        push_cmd(make_cmd(KIND_RSVD_FIRST, '1, '1, '1, '1));
        push_cmd(make_cmd(KIND_RSVD_LAST, '0, '0, '0, '0));
        push_cmd(make_cmd(KIND_ALLOC, '0, '0, '0, '0));

        while (cmds_queued < 125) random_step();
        wait_drained();

        send_idle_pct = 76;
        recv_idle_pct = 6;
        while (cmds_queued < 225) random_step();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (cmds_queued < 325) random_step();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && due_replies.size() == 0)
            $display("** software_timer_table_top: PASSED **");
        else
            $display("** software_timer_table_top: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** software_timer_table_top: FAILED **");
        $finish;
    end

endmodule
